// ===== src/kmb_pkg.sv =====
package kmb_pkg;

	localparam int unsigned ALPHABET_SIZE = 4;
	localparam int unsigned MAX_ORDER = 4;
	localparam int unsigned COUNT_WIDTH = 32;

	// longest k-mer any legal MAX_ORDER can ask for, plus one for the table size
	localparam int unsigned LEN_LIMIT = 8;
	localparam int unsigned HIST_LIMIT_W = 2 * LEN_LIMIT;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned BASE_W = 3;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned SYM_W = 3;
	localparam int unsigned ORDER_W = 3;
	localparam int unsigned CUM_EXTRA = 2;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TRAIN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd2;

	typedef struct packed {
		logic start;
		logic den_load;
		logic row_load;
		logic row_last;
		logic [SYM_W-1:0] letter;
	} sel_ctl_t;

	typedef struct packed {
		logic done;
		logic fell_back;
		logic [SYM_W-1:0] symbol;
	} sel_res_t;

	// first table entry of the group of k-mers of length n
	function automatic int unsigned group_base(input int unsigned n, input int unsigned a);
		int unsigned off;
		int unsigned p;
		off = 0;
		p = 1;
		for (int unsigned m = 1; m < LEN_LIMIT; m++) begin
			if (m < n) begin
				p = p * a;
				off = off + p;
			end
		end
		return off;
	endfunction

	// base-a value of the newest n letters, oldest letter most significant
	function automatic int unsigned hist_index(input logic [HIST_LIMIT_W-1:0] hist,
			input int unsigned n, input int unsigned a);
		int unsigned idx;
		idx = 0;
		for (int unsigned j = 1; j < LEN_LIMIT; j++) begin
			if (LEN_LIMIT - j <= n) begin
				idx = idx * a + 32'(hist[2 * (LEN_LIMIT - 1 - j) +: 2]);
			end
		end
		return idx;
	endfunction

endpackage

// ===== src/kmer_markov_background_sampler_unit.sv =====
// Markov background sampler over k-mer counts. The k-mer counters live in one single-port-read,
// single-port-write table of sum(A^k, k=1..MAX_ORDER+1) entries (1364 at the defaults), so
// every item is a short sequence of table accesses: a training beat updates k counters before
// the next beat is taken, k = min(order+1, defined run), each counter read and its saturated
// value written back in the cycle after, overlapping the following read; an undefined base
// makes no table access. A sampling beat does one prefix read (the total register at context
// length zero), one read per letter, then the three-stage threshold pipeline (r*prefix product,
// cumulative*65535, compare). A clear beat, and reset, start a sweep that zeroes the table one
// entry a cycle; no input beat is taken until the sweep ends, while configuration writes are
// always taken. A finished symbol waits in the output register, and the next beat is accepted
// meanwhile.
module kmer_markov_background_sampler_unit #(
	parameter int unsigned ALPHABET_SIZE = kmb_pkg::ALPHABET_SIZE,
	parameter int unsigned MAX_ORDER = kmb_pkg::MAX_ORDER,
	parameter int unsigned COUNT_WIDTH = kmb_pkg::COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kmb_pkg::ORDER_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kmb_pkg::FUNC_W-1:0]    func,
	input  logic                          first,
	input  logic [kmb_pkg::BASE_W-1:0]    base,
	input  logic [kmb_pkg::FRAC_W-1:0]    random_fraction,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kmb_pkg::SYM_W-1:0]     symbol,
	output logic                          fell_back
);

	localparam int unsigned DEPTH = kmb_pkg::group_base(MAX_ORDER + 2, ALPHABET_SIZE);
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [kmb_pkg::ORDER_W-1:0]  model_order_q;
	logic                         out_valid_q;
	logic [kmb_pkg::SYM_W-1:0]    symbol_q;
	logic                         fell_back_q;

	logic                         rd_en;
	logic [ADDR_W-1:0]            rd_addr;
	logic [COUNT_WIDTH-1:0]       rd_data;
	logic                         wr_en;
	logic [ADDR_W-1:0]            wr_addr;
	logic [COUNT_WIDTH-1:0]       wr_data;
	kmb_pkg::sel_ctl_t            sel_ctl;
	kmb_pkg::sel_res_t            sel_res;
	logic [COUNT_WIDTH-1:0]       den;
	logic [kmb_pkg::FRAC_W-1:0]   frac;
	logic                         out_free;
	logic                         res_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_order_q <= kmb_pkg::ORDER_RESET;
		end else if (cfg_valid) begin
			model_order_q <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			symbol_q <= sel_res.symbol;
			fell_back_q <= sel_res.fell_back;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol = symbol_q;
	assign fell_back = fell_back_q;

	kmb_seq #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.MAX_ORDER     (MAX_ORDER),
		.COUNT_W       (COUNT_WIDTH),
		.DEPTH         (DEPTH),
		.ADDR_W        (ADDR_W)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.first           (first),
		.base            (base),
		.random_fraction (random_fraction),
		.model_order     (model_order_q),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.sel_ctl         (sel_ctl),
		.den             (den),
		.frac            (frac),
		.sel_res         (sel_res),
		.out_free        (out_free),
		.res_load        (res_load)
	);

	kmb_count_mem #(
		.DEPTH   (DEPTH),
		.ADDR_W  (ADDR_W),
		.COUNT_W (COUNT_WIDTH)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	kmb_sel #(
		.COUNT_W (COUNT_WIDTH)
	) u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sel_ctl),
		.den    (den),
		.cnt    (rd_data),
		.frac   (frac),
		.res    (sel_res)
	);

endmodule

// ===== src/kmb_count_mem.sv =====
module kmb_count_mem #(
	parameter int unsigned DEPTH = 1364,
	parameter int unsigned ADDR_W = 11,
	parameter int unsigned COUNT_W = kmb_pkg::COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [COUNT_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [COUNT_W-1:0] wr_data
);

	logic [COUNT_W-1:0] mem_q [DEPTH];
	logic [COUNT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/kmb_sel.sv =====
module kmb_sel #(
	parameter int unsigned COUNT_W = kmb_pkg::COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kmb_pkg::sel_ctl_t             ctl,
	input  logic [COUNT_W-1:0]            den,
	input  logic [COUNT_W-1:0]            cnt,
	input  logic [kmb_pkg::FRAC_W-1:0]    frac,
	output kmb_pkg::sel_res_t             res
);

	localparam int unsigned LHS_W = kmb_pkg::FRAC_W + COUNT_W;
	localparam int unsigned CUM_W = COUNT_W + kmb_pkg::CUM_EXTRA;
	localparam int unsigned SC_W = CUM_W + kmb_pkg::FRAC_W;

	logic [LHS_W-1:0]            lhs_q;
	logic                        den_zero_q;
	logic [CUM_W-1:0]            cum_q;
	logic                        v_s1;
	logic                        last_s1;
	logic [kmb_pkg::SYM_W-1:0]   letter_s1;
	logic [SC_W-1:0]             scaled_s2;
	logic                        v_s2;
	logic                        last_s2;
	logic [kmb_pkg::SYM_W-1:0]   letter_s2;
	logic                        found_q;
	logic [kmb_pkg::SYM_W-1:0]   sym_q;
	logic                        done_q;
	logic                        hit;

	// r * prefix count, taken once per sample
	always_ff @(posedge clk) begin
		if (ctl.den_load) begin
			lhs_q <= LHS_W'(frac) * LHS_W'(den);
			den_zero_q <= (den == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				cum_q <= '0;
			end else if (ctl.row_load) begin
				cum_q <= cum_q + CUM_W'(cnt);
			end
			v_s1 <= ctl.row_load;
			last_s1 <= ctl.row_load & ctl.row_last;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			if (ctl.start) begin
				found_q <= 1'b0;
			end else if (hit && !found_q) begin
				found_q <= 1'b1;
			end
			done_q <= v_s2 & last_s2;
		end
	end

	// cumulative count times 65535
	always_ff @(posedge clk) begin
		letter_s1 <= ctl.letter;
		scaled_s2 <= {cum_q, kmb_pkg::FRAC_W'(0)} - SC_W'(cum_q);
		letter_s2 <= letter_s1;
		if (hit && !found_q) begin
			sym_q <= letter_s2;
		end
	end

	assign hit = v_s2 && !den_zero_q && (SC_W'(lhs_q) <= scaled_s2);

	assign res.done = done_q;
	assign res.fell_back = !found_q;
	assign res.symbol = found_q ? sym_q : kmb_pkg::SYM_W'(1);

endmodule

// ===== src/kmb_seq.sv =====
module kmb_seq #(
	parameter int unsigned ALPHABET_SIZE = kmb_pkg::ALPHABET_SIZE,
	parameter int unsigned MAX_ORDER = kmb_pkg::MAX_ORDER,
	parameter int unsigned COUNT_W = kmb_pkg::COUNT_WIDTH,
	parameter int unsigned DEPTH = 1364,
	parameter int unsigned ADDR_W = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kmb_pkg::FUNC_W-1:0]    func,
	input  logic                          first,
	input  logic [kmb_pkg::BASE_W-1:0]    base,
	input  logic [kmb_pkg::FRAC_W-1:0]    random_fraction,
	input  logic [kmb_pkg::ORDER_W-1:0]   model_order,
	output logic                          rd_en,
	output logic [ADDR_W-1:0]             rd_addr,
	input  logic [COUNT_W-1:0]            rd_data,
	output logic                          wr_en,
	output logic [ADDR_W-1:0]             wr_addr,
	output logic [COUNT_W-1:0]            wr_data,
	output kmb_pkg::sel_ctl_t             sel_ctl,
	output logic [COUNT_W-1:0]            den,
	output logic [kmb_pkg::FRAC_W-1:0]    frac,
	input  kmb_pkg::sel_res_t             sel_res,
	input  logic                          out_free,
	output logic                          res_load
);

	localparam int unsigned NW = $clog2(MAX_ORDER + 3);
	localparam int unsigned HW = 2 * (MAX_ORDER + 1);
	localparam int unsigned LW = $clog2(ALPHABET_SIZE);

	typedef enum logic [6:0] {
		ST_CLR   = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_TRAIN = 7'b0000100,
		ST_DEN   = 7'b0001000,
		ST_ROW   = 7'b0010000,
		ST_WAIT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t                      state_q;
	logic [ADDR_W-1:0]           clr_addr_q;
	logic [HW-1:0]               train_hist_q;
	logic [NW-1:0]               dr_q;
	logic [COUNT_W-1:0]          total_q;
	logic [NW-1:0]               kcnt_q;
	logic [NW-1:0]               n_q;
	logic                        pend_s1;
	logic [ADDR_W-1:0]           waddr_s1;
	logic [HW-1:0]               samp_hist_q;
	logic [NW-1:0]               pos_q;
	logic [NW-1:0]               c_q;
	logic [kmb_pkg::FRAC_W-1:0]  r_q;
	logic [ADDR_W-1:0]           rowbase_q;
	logic [LW-1:0]               letter_q;
	logic                        den_s1;
	logic                        den_total_s1;
	logic                        row_s1;
	logic                        last_s1;
	logic [kmb_pkg::SYM_W-1:0]   letter_s1;

	logic                        accept;
	logic [NW-1:0]               ord;
	logic [HW-1:0]               hist_t;
	logic [NW-1:0]               dr_t;
	logic                        defined;
	logic [NW-1:0]               dr_inc;
	logic [NW-1:0]               kmax;
	logic [HW-1:0]               sh_t;
	logic [NW-1:0]               sp_t;
	logic [ADDR_W-1:0]           tr_idx;
	logic [31:0]                 ctx;
	logic [ADDR_W-1:0]           den_addr;
	logic [ADDR_W-1:0]           rowbase_next;
	logic                        row_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid & in_ready;

	assign ord = (model_order > kmb_pkg::ORDER_W'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(model_order);

	// training bookkeeping for the accepted beat
	assign hist_t = first ? '0 : train_hist_q;
	assign dr_t = first ? '0 : dr_q;
	assign defined = (base != '0) && (base <= kmb_pkg::BASE_W'(ALPHABET_SIZE));
	assign dr_inc = (dr_t < NW'(MAX_ORDER + 1)) ? dr_t + NW'(1) : dr_t;
	assign kmax = ord + NW'(1);

	assign sh_t = first ? '0 : samp_hist_q;
	assign sp_t = first ? '0 : pos_q;

	assign tr_idx = ADDR_W'(kmb_pkg::group_base(32'(n_q), ALPHABET_SIZE)
		+ kmb_pkg::hist_index(kmb_pkg::HIST_LIMIT_W'(train_hist_q), 32'(n_q), ALPHABET_SIZE));

	assign ctx = kmb_pkg::hist_index(kmb_pkg::HIST_LIMIT_W'(samp_hist_q), 32'(c_q),
		ALPHABET_SIZE);
	assign den_addr = ADDR_W'(kmb_pkg::group_base(32'(c_q), ALPHABET_SIZE) + ctx);
	assign rowbase_next = ADDR_W'(kmb_pkg::group_base(32'(c_q) + 32'd1, ALPHABET_SIZE)
		+ ctx * ALPHABET_SIZE);

	assign row_last = (letter_q == LW'(ALPHABET_SIZE - 1));
	assign res_load = (state_q == ST_OUT) && out_free;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = tr_idx;
		case (state_q)
			ST_TRAIN: begin
				rd_en = 1'b1;
				rd_addr = tr_idx;
			end
			ST_DEN: begin
				rd_en = (c_q != '0);
				rd_addr = den_addr;
			end
			ST_ROW: begin
				rd_en = 1'b1;
				rd_addr = rowbase_q + ADDR_W'(letter_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// clearing sweep shares the write port with the count write-back
	always_comb begin
		if (state_q == ST_CLR) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en = pend_s1;
			wr_addr = waddr_s1;
			wr_data = (rd_data == '1) ? rd_data : rd_data + COUNT_W'(1);
		end
	end

	assign sel_ctl.start = (state_q == ST_DEN);
	assign sel_ctl.den_load = den_s1;
	assign sel_ctl.row_load = row_s1;
	assign sel_ctl.row_last = last_s1;
	assign sel_ctl.letter = letter_s1;
	assign den = den_total_s1 ? total_q : rd_data;
	assign frac = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_addr_q <= '0;
			train_hist_q <= '0;
			dr_q <= '0;
			total_q <= '0;
			kcnt_q <= '0;
			n_q <= '0;
			pend_s1 <= 1'b0;
			samp_hist_q <= '0;
			pos_q <= '0;
			c_q <= '0;
			letter_q <= '0;
			den_s1 <= 1'b0;
			row_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_TRAIN);
			den_s1 <= (state_q == ST_DEN);
			row_s1 <= (state_q == ST_ROW);
			last_s1 <= row_last;
			case (state_q)
				ST_CLR: begin
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (func)
							kmb_pkg::FUNC_CLEAR: begin
								total_q <= '0;
								train_hist_q <= '0;
								dr_q <= '0;
								clr_addr_q <= '0;
								state_q <= ST_CLR;
							end
							kmb_pkg::FUNC_TRAIN: begin
								if (defined) begin
									train_hist_q <= HW'({hist_t, 2'(base - kmb_pkg::BASE_W'(1))});
									dr_q <= dr_inc;
									kcnt_q <= (dr_inc < kmax) ? dr_inc : kmax;
									n_q <= NW'(1);
									total_q <= (total_q == '1) ? total_q : total_q + COUNT_W'(1);
									state_q <= ST_TRAIN;
								end else begin
									train_hist_q <= hist_t;
									dr_q <= '0;
								end
							end
							kmb_pkg::FUNC_SAMPLE: begin
								samp_hist_q <= sh_t;
								pos_q <= sp_t;
								c_q <= (sp_t < ord) ? sp_t : ord;
								state_q <= ST_DEN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TRAIN: begin
					n_q <= n_q + NW'(1);
					if (n_q == kcnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DEN: begin
					letter_q <= '0;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					letter_q <= letter_q + LW'(1);
					if (row_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (sel_res.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						samp_hist_q <= HW'({samp_hist_q,
							2'(sel_res.symbol - kmb_pkg::SYM_W'(1))});
						if (pos_q < NW'(MAX_ORDER)) begin
							pos_q <= pos_q + NW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= tr_idx;
		den_total_s1 <= (c_q == '0);
		letter_s1 <= kmb_pkg::SYM_W'(letter_q) + kmb_pkg::SYM_W'(1);
		if (accept) begin
			r_q <= random_fraction;
		end
		if (state_q == ST_DEN) begin
			rowbase_q <= rowbase_next;
		end
	end

`ifndef SYNTHESIS
	a_clr_no_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !pend_s1)
		else $error("count write-back overlaps clearing sweep");

	a_train_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRAIN) |-> (n_q != '0 && n_q <= kcnt_q))
		else $error("k-mer length out of range during training");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dr_q <= NW'(MAX_ORDER + 1)) && (pos_q <= NW'(MAX_ORDER)))
		else $error("defined run or sample position past its limit");

	a_row_after_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW && letter_q == '0) |-> $past(state_q == ST_DEN))
		else $error("row reads started without a prefix read");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
	import kmb_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 10000;
	localparam int unsigned CFG_PAUSE = 1400;
	localparam int unsigned DRAIN_TAIL = 50;
	localparam int unsigned RANDOM_ITEMS = 1450;
	localparam int unsigned PHASES = 8;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [BASE_W-1:0] BASE_UNDEFINED = '0;
	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	class symbol_scoreboard;
		typedef struct packed {
			logic [kmb_pkg::SYM_W-1:0] symbol;
			logic fell_back;
		} symbol_beat_t;
		localparam int unsigned HIST_W = 2 * (kmb_pkg::MAX_ORDER + 1);
		localparam int unsigned LETTERS = kmb_pkg::ALPHABET_SIZE;

		logic [kmb_pkg::COUNT_WIDTH-1:0] tally [int unsigned];
		logic [kmb_pkg::COUNT_WIDTH-1:0] single_total;
		logic [HIST_W-1:0] trained_tail;
		logic [HIST_W-1:0] sampled_tail;
		int unsigned run_len;
		int unsigned sampled_len;
		int unsigned order_in_use;
		symbol_beat_t expected_symbols [$];
		int unsigned mismatches;

		function new();
			clear_tally();
			sampled_tail = '0;
			sampled_len = 0;
			order_in_use = kmb_pkg::ORDER_RESET;
			mismatches = 0;
		endfunction

		function void clear_tally();
			tally.delete();
			single_total = '0;
			trained_tail = '0;
			run_len = 0;
		endfunction

		function void set_order(input logic [kmb_pkg::ORDER_W-1:0] v);
			order_in_use = (v > kmb_pkg::MAX_ORDER) ? kmb_pkg::MAX_ORDER : v;
		endfunction

		// table offset of the k-mers of length len
		function int unsigned group_start(input int unsigned len);
			int unsigned off;
			int unsigned p;
			off = 0;
			p = 1;
			for (int unsigned m = 1; m < len; m++) begin
				p = p * LETTERS;
				off = off + p;
			end
			return off;
		endfunction

		// newest len letters as a number, oldest letter most significant
		function int unsigned tail_value(input logic [HIST_W-1:0] tail, input int unsigned len);
			int unsigned v;
			v = 0;
			for (int unsigned i = len; i > 0; i--) begin
				v = v * LETTERS + int'((tail >> (2 * (i - 1))) & 3);
			end
			return v;
		endfunction

		function logic [kmb_pkg::COUNT_WIDTH-1:0] tally_at(input int unsigned idx);
			return tally.exists(idx) ? tally[idx] : '0;
		endfunction

		function void train_base(input logic fst, input logic [kmb_pkg::BASE_W-1:0] b);
			int unsigned idx;
			if (fst) begin
				trained_tail = '0;
				run_len = 0;
			end
			if (b == 0 || b > LETTERS) begin
				run_len = 0;
				return;
			end
			trained_tail = {trained_tail[HIST_W-3:0], 2'(b - 1)};
			if (run_len < kmb_pkg::MAX_ORDER + 1)
				run_len++;
			for (int unsigned len = 1; len <= order_in_use + 1 && len <= run_len; len++) begin
				idx = group_start(len) + tail_value(trained_tail, len);
				if (tally_at(idx) != '1)
					tally[idx] = tally_at(idx) + 1'b1;
			end
			if (single_total != '1)
				single_total++;
		endfunction

		function void sample_symbol(input logic fst, input logic [kmb_pkg::FRAC_W-1:0] r);
			int unsigned ctx_len;
			int unsigned ctx;
			int unsigned row;
			logic [kmb_pkg::COUNT_WIDTH-1:0] prefix;
			logic [63:0] scaled;
			logic [63:0] cum;
			symbol_beat_t want;
			if (fst) begin
				sampled_tail = '0;
				sampled_len = 0;
			end
			ctx_len = (sampled_len < order_in_use) ? sampled_len : order_in_use;
			ctx = tail_value(sampled_tail, ctx_len);
			prefix = (ctx_len == 0) ? single_total : tally_at(group_start(ctx_len) + ctx);
			row = group_start(ctx_len + 1) + ctx * LETTERS;
			want.symbol = 1;
			want.fell_back = 1'b1;
			// no division: r * prefix against 65535 * running sum
			if (prefix != '0) begin
				scaled = 64'(r) * 64'(prefix);
				cum = '0;
				for (int unsigned a = 1; a <= LETTERS; a++) begin
					cum = cum + 64'(tally_at(row + a - 1));
					if (scaled <= cum * 64'((1 << kmb_pkg::FRAC_W) - 1)) begin
						want.symbol = kmb_pkg::SYM_W'(a);
						want.fell_back = 1'b0;
						break;
					end
				end
			end
			sampled_tail = {sampled_tail[HIST_W-3:0], 2'(want.symbol - 1)};
			if (sampled_len < kmb_pkg::MAX_ORDER)
				sampled_len++;
			expected_symbols.insert(expected_symbols.size(), want);
		endfunction

		function void note_beat(input logic [kmb_pkg::FUNC_W-1:0] f, input logic fst,
				input logic [kmb_pkg::BASE_W-1:0] b, input logic [kmb_pkg::FRAC_W-1:0] r);
			case (f)
				kmb_pkg::FUNC_CLEAR: clear_tally();
				kmb_pkg::FUNC_TRAIN: train_base(fst, b);
				kmb_pkg::FUNC_SAMPLE: sample_symbol(fst, r);
				default: ;
			endcase
		endfunction

		function void check_symbol(input logic [kmb_pkg::SYM_W-1:0] got_symbol,
				input logic got_fell_back);
			symbol_beat_t want;
			if (expected_symbols.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: symbol beat with none expected: symbol %0d fell_back %0d",
						$time, got_symbol, got_fell_back);
				mismatches++;
				return;
			end
			want = expected_symbols.pop_front();
			if (got_symbol !== want.symbol || got_fell_back !== want.fell_back) begin
				if (mismatches < 10)
					$display("%0t: symbol mismatch: expected %0d/%0d, got %0d/%0d (symbol/fell_back)",
						$time, want.symbol, want.fell_back, got_symbol, got_fell_back);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ORDER_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic first = 1'b0;
	logic [BASE_W-1:0] base = '0;
	logic [FRAC_W-1:0] random_fraction = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SYM_W-1:0] symbol;
	logic fell_back;

	symbol_scoreboard sb;
	bit src_quiet = 1'b0;
	bit snk_quiet = 1'b0;
	int unsigned stall_cycles = 0;
	logic [ORDER_W-1:0] order_plan [PHASES-1] = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6};

	kmer_markov_background_sampler_unit i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned roll;
		if (quiet)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic fst,
			input logic [BASE_W-1:0] b, input logic [FRAC_W-1:0] r);
		int unsigned gap;
		if ($urandom_range(63) == 0)
			src_quiet = !src_quiet;
		gap = pick_gap(src_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		first <= fst;
		base <= b;
		random_fraction <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending, wait for every outstanding symbol, then hold off
	task automatic settle(input int unsigned extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_symbols.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_order(input logic [ORDER_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_symbol(symbol, fell_back);
		if (in_valid && in_ready)
			sb.note_beat(func, first, base, random_fraction);
		if (cfg_valid && cfg_ready)
			sb.set_order(cfg_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(63) == 0)
				snk_quiet = !snk_quiet;
			stall = pick_gap(snk_quiet);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int unsigned sent;
		int unsigned len;
		int unsigned kind;
		logic fst;
		logic [BASE_W-1:0] b;
		logic [FRAC_W-1:0] r;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, then a short trained sequence
		send_item(FUNC_SAMPLE, 1'b1, 3'd0, 16'd12345);
		send_item(FUNC_UNUSED, 1'b1, 3'd7, FRAC_MAX);
		send_item(FUNC_TRAIN, 1'b1, 3'd1, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd2, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd1, 16'd0);
		send_item(FUNC_SAMPLE, 1'b1, 3'd0, 16'd0);
		// context counted more often than its successors (the last A has none): no threshold met
		send_item(FUNC_SAMPLE, 1'b0, 3'd0, FRAC_MAX);
		send_item(FUNC_TRAIN, 1'b0, BASE_UNDEFINED, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd7, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd4, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd3, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd5, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd4, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd4, 16'd0);
		send_item(FUNC_SAMPLE, 1'b1, 3'd6, FRAC_MAX);
		send_item(FUNC_SAMPLE, 1'b0, 3'd0, 16'd32768);
		send_item(FUNC_SAMPLE, 1'b0, 3'd0, 16'd1);
		send_item(FUNC_SAMPLE, 1'b0, 3'd0, FRAC_MAX);
		send_item(FUNC_CLEAR, 1'b0, 3'd0, 16'd0);
		send_item(FUNC_SAMPLE, 1'b1, 3'd0, 16'd40000);
		send_item(FUNC_TRAIN, 1'b1, 3'd2, 16'd0);
		send_item(FUNC_TRAIN, 1'b0, 3'd4, 16'd0);
		send_item(FUNC_SAMPLE, 1'b1, 3'd0, 16'd50000);
		settle(0);

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				settle(CFG_PAUSE);
				write_order(order_plan[ph - 1]);
			end
			if ($urandom_range(2) == 0)
				send_item(FUNC_CLEAR, 1'($urandom), BASE_W'($urandom), FRAC_W'($urandom));
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				kind = $urandom_range(99);
				if (kind < 45) begin
					len = $urandom_range(1, 30);
					for (int unsigned i = 0; i < len; i++) begin
						fst = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
						if ($urandom_range(15) == 0)
							b = ($urandom_range(3) == 0) ? BASE_UNDEFINED :
								BASE_W'($urandom_range(ALPHABET_SIZE + 1, 7));
						else
							b = BASE_W'($urandom_range(1, ALPHABET_SIZE));
						send_item(FUNC_TRAIN, fst, b, FRAC_W'($urandom));
					end
					sent += len;
				end else if (kind < 90) begin
					len = $urandom_range(1, 10);
					for (int unsigned i = 0; i < len; i++) begin
						fst = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
						case ($urandom_range(7))
							0: r = '0;
							1: r = FRAC_MAX;
							default: r = FRAC_W'($urandom);
						endcase
						send_item(FUNC_SAMPLE, fst, BASE_W'($urandom), r);
					end
					sent += len;
				end else if (kind < 97) begin
					send_item(FUNC_UNUSED, 1'($urandom), BASE_W'($urandom), FRAC_W'($urandom));
				end else if (kind < 99) begin
					settle(0);
				end else begin
					send_item(FUNC_CLEAR, 1'($urandom), BASE_W'($urandom), FRAC_W'($urandom));
					sent++;
				end
			end
		end

		settle(DRAIN_TAIL);
		if (sb.mismatches == 0 && sb.expected_symbols.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/kmb_pkg.sv
src/kmb_count_mem.sv
src/kmb_sel.sv
src/kmb_seq.sv
src/kmer_markov_background_sampler_unit.sv
dv/testbench.sv
